// File: rtl/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared constants and types of the request suffix scanner: word codes,
// result codes, suffix patterns and the match flag bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

    // Window of most recent received bytes
    localparam int WINDOW_BYTES = 9;
    localparam int WIN_W        = 8 * WINDOW_BYTES;

    typedef logic [WIN_W-1:0] win_t;

    // Input word kinds (s_tuser)
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Result kinds (m_tuser)
    localparam logic [2:0] RK_CONN_ID = 3'd0;
    localparam logic [2:0] RK_FAVICON = 3'd1;
    localparam logic [2:0] RK_HOME    = 3'd2;
    localparam logic [2:0] RK_RELAY   = 3'd3;
    localparam logic [2:0] RK_TIMEOUT = 3'd4;

    localparam int VALUE_W = 13;

    localparam logic [VALUE_W-1:0] VAL_FAVICON = 13'd5;
    localparam logic [VALUE_W-1:0] VAL_HOME    = 13'd6;
    localparam logic [VALUE_W-1:0] VAL_TIMEOUT = '1;
    localparam logic [VALUE_W-1:0] ASCII_ZERO  = 13'd48;

    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;

    localparam logic [15:0] TIMEOUT_RESET = 16'd50;

    // Suffix patterns, right aligned: last character in the low byte
    localparam win_t PAT_IPD     = win_t'("+IPD,");
    localparam win_t PAT_FAVICON = win_t'("/favicon");
    localparam win_t PAT_HOME    = win_t'("GET / ");
    localparam win_t PAT_REL     = win_t'("GET /?rel");

    // Compare masks covering the pattern length
    localparam win_t MASK_IPD     = win_t'({5{8'hff}});
    localparam win_t MASK_FAVICON = win_t'({8{8'hff}});
    localparam win_t MASK_HOME    = win_t'({6{8'hff}});
    localparam win_t MASK_REL     = win_t'({9{8'hff}});

    // Suffix hits on the updated window
    typedef struct packed {
        logic ipd;
        logic favicon;
        logic home;
        logic rel;
    } match_t;

endpackage

`default_nettype wire

// File: rtl/rss_match.sv
// ----------------------------------------------------------------------------
// rss_match
// Parallel suffix compare of the byte window against the fixed patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_match (
    input  wire rss_pkg::win_t   window,
    output rss_pkg::match_t      hits
);
    import rss_pkg::*;

    // Masked compare of the newest bytes; empty slots are zero and never hit
    always_comb begin
        hits.ipd     = ((window ^ PAT_IPD)     & MASK_IPD)     == '0;
        hits.favicon = ((window ^ PAT_FAVICON) & MASK_FAVICON) == '0;
        hits.home    = ((window ^ PAT_HOME)    & MASK_HOME)    == '0;
        hits.rel     = ((window ^ PAT_REL)     & MASK_REL)     == '0;
    end

endmodule

`default_nettype wire

// File: rtl/request_suffix_scanner.sv
// A result word is registered and appears on m_* in the cycle after the word that causes it.
// Throughput: one input word per cycle; the window update, suffix compare and
// phase logic are all combinational ahead of the output register.
// s_tready drops only while a result is held and m_tready is low.
// Reset (aresetn low, synchronous): no session, output empty, timeout_ms = 50.
// ----------------------------------------------------------------------------
// request_suffix_scanner
// Scans a received byte stream for request suffixes and reports connection
// id, favicon, homepage, relay command or session timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module request_suffix_scanner (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration: timeout_ms
    input  wire         cfg_wr_en,
    input  wire  [15:0] cfg_wr_data,
    // input channel
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    input  wire  [1:0]  s_tuser,   // [1:0] kind
    // result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [12:0] result_value, [15:13] zero
    output logic [2:0]  m_tuser    // [2:0] result_kind
);
    import rss_pkg::*;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_ID    = 2'd1,
        PH_DIGIT = 2'd2,
        PH_SIGN  = 2'd3
    } phase_t;

    logic [15:0]        timeout_reg;
    logic               active_reg, active_next;
    phase_t             phase_reg, phase_next;
    logic [VALUE_W-1:0] relay_reg, relay_next;
    win_t               win_reg, win_next;
    logic [15:0]        elapsed_reg, elapsed_next;

    logic               m_valid_reg;
    logic [2:0]         m_kind_reg;
    logic [VALUE_W-1:0] m_value_reg;

    logic               s_acc;
    logic               emit;
    logic [2:0]         emit_kind;
    logic [VALUE_W-1:0] emit_value;
    logic [VALUE_W-1:0] digit;
    phase_t             ph_mid;
    match_t             hits;
    win_t               win_shift;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {3'b000, m_value_reg};

    // Window with the incoming byte shifted in
    assign win_shift = {win_reg[WIN_W-9:0], s_tdata};

    rss_match u_match (
        .window (win_shift),
        .hits   (hits)
    );

    // Incoming byte minus ASCII zero
    assign digit = {5'b0_0000, s_tdata} - ASCII_ZERO;

    // Per-word session logic, checks in priority order
    always_comb begin
        active_next  = active_reg;
        phase_next   = phase_reg;
        relay_next   = relay_reg;
        win_next     = win_reg;
        elapsed_next = elapsed_reg;
        emit         = 1'b0;
        emit_kind    = RK_CONN_ID;
        emit_value   = '0;
        ph_mid       = phase_reg;

        case (s_tuser)
            KIND_START: begin
                active_next  = 1'b1;
                phase_next   = PH_PLAIN;
                relay_next   = '0;
                win_next     = '0;
                elapsed_next = '0;
            end
            KIND_TICK: begin
                if (active_reg) begin
                    if (elapsed_reg != 16'hffff) begin
                        elapsed_next = elapsed_reg + 16'd1;
                    end
                    if (elapsed_next > timeout_reg) begin
                        emit       = 1'b1;
                        emit_kind  = RK_TIMEOUT;
                        emit_value = VAL_TIMEOUT;
                    end
                end
            end
            KIND_BYTE: begin
                if (active_reg) begin
                    win_next = win_shift;
                    if (phase_reg == PH_ID) begin
                        emit       = 1'b1;
                        emit_kind  = RK_CONN_ID;
                        emit_value = digit;
                    end else begin
                        if (hits.ipd) begin
                            ph_mid = PH_ID;
                        end
                        phase_next = ph_mid;
                        if (hits.favicon) begin
                            emit       = 1'b1;
                            emit_kind  = RK_FAVICON;
                            emit_value = VAL_FAVICON;
                        end else if (hits.home) begin
                            emit       = 1'b1;
                            emit_kind  = RK_HOME;
                            emit_value = VAL_HOME;
                        end else if (ph_mid == PH_SIGN && s_tdata == CHAR_MINUS) begin
                            emit       = 1'b1;
                            emit_kind  = RK_RELAY;
                            emit_value = relay_reg;
                        end else if (ph_mid == PH_SIGN && s_tdata == CHAR_PLUS) begin
                            emit       = 1'b1;
                            emit_kind  = RK_RELAY;
                            emit_value = relay_reg + 13'd1;
                        end else begin
                            if (ph_mid == PH_DIGIT) begin
                                // digit * 10 as shift-add
                                relay_next = (digit << 3) + (digit << 1);
                                phase_next = PH_SIGN;
                            end
                            if (hits.rel) begin
                                phase_next = PH_DIGIT;
                            end
                        end
                    end
                end
            end
            default: begin
                // unused kind: ignored
            end
        endcase

        // any result closes the session
        if (emit) begin
            active_next = 1'b0;
        end
    end

    // State and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            active_reg  <= 1'b0;
            phase_reg   <= PH_PLAIN;
            relay_reg   <= '0;
            win_reg     <= '0;
            elapsed_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            if (s_acc) begin
                active_reg  <= active_next;
                phase_reg   <= phase_next;
                relay_reg   <= relay_next;
                win_reg     <= win_next;
                elapsed_reg <= elapsed_next;
            end
            if (s_acc && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (s_acc && emit) begin
            m_kind_reg  <= emit_kind;
            m_value_reg <= emit_value;
        end
    end

    // Checks
    a_timeout_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == RK_TIMEOUT |-> m_tdata[VALUE_W-1:0] == VAL_TIMEOUT)
        else $error("timeout result without value -1");

    a_fixed_values: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == RK_FAVICON || m_tuser == RK_HOME) |->
            m_tdata[VALUE_W-1:0] == (m_tuser == RK_FAVICON ? VAL_FAVICON : VAL_HOME))
        else $error("favicon or homepage result with wrong value");

    a_emit_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && emit |=> !active_reg && m_tvalid)
        else $error("session still open or no result after emitting word");

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tuser == KIND_START |=>
            active_reg && elapsed_reg == '0 && phase_reg == PH_PLAIN)
        else $error("start word did not open a cleared session");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && !active_reg && s_tuser != KIND_START |=> $stable(win_reg) && !active_reg)
        else $error("idle word changed session state");

endmodule

`default_nettype wire

// File: tb/scan_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scan_result_checker
// Watches the input, result and configuration ports of the request suffix
// scanner. It keeps its own copy of the scan state, works out the result that
// each accepted input word causes, and compares every result word field by
// field with the oldest result still due.
// ----------------------------------------------------------------------------
module scan_result_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [15:0] cfg_wr_data,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    input  wire  [1:0]  s_tuser,   // [1:0] kind
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [15:0] m_tdata,   // [12:0] result_value, [15:13] zero
    input  wire  [2:0]  m_tuser,   // [2:0] result_kind
    output int          fail_count,
    output int          pending_count
);
    import rss_pkg::*;

    localparam int DIGIT_ZERO = 48;

    // Suffixes, last character in the low byte
    localparam logic [39:0] SFX_IPD     = "+IPD,";
    localparam logic [63:0] SFX_FAVICON = "/favicon";
    localparam logic [47:0] SFX_HOME    = "GET / ";
    localparam logic [71:0] SFX_REL     = "GET /?rel";

    typedef enum logic [1:0] {PH_PLAIN, PH_ID, PH_DIGIT, PH_SIGN} scan_phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [12:0] value;
    } reply_t;

    reply_t      replies_due[$];
    int          mismatches = 0;

    // Predicted scanner state
    logic [15:0] limit_ms;
    logic        in_session;
    scan_phase_t phase;
    int          relay_base;
    logic [71:0] history;     // newest byte in [7:0]
    logic [15:0] elapsed;

    task automatic report(input string what, input int got, input int want);
        $display("%0t ns  %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Queue a reply; any reply closes the session
    function automatic void post(input logic [2:0] k, input int v);
        replies_due.push_back(reply_t'({k, v[12:0]}));
        in_session = 1'b0;
    endfunction

    function automatic void scan_word(input logic [1:0] kind, input logic [7:0] b);
        if (kind == KIND_START) begin
            in_session = 1'b1;
            phase      = PH_PLAIN;
            relay_base = 0;
            elapsed    = '0;
            history    = '0;
        end else if (in_session && kind == KIND_TICK) begin
            if (elapsed != 16'hffff)
                elapsed = elapsed + 16'd1;
            if (elapsed > limit_ms)
                post(RK_TIMEOUT, -1);
        end else if (in_session && kind == KIND_BYTE) begin
            history = {history[63:0], b};
            if (phase == PH_ID) begin
                post(RK_CONN_ID, int'(b) - DIGIT_ZERO);
            end else begin
                if (history[39:0] == SFX_IPD)
                    phase = PH_ID;
                if (history[63:0] == SFX_FAVICON) begin
                    post(RK_FAVICON, 5);
                end else if (history[47:0] == SFX_HOME) begin
                    post(RK_HOME, 6);
                end else if (phase == PH_SIGN && b == CHAR_MINUS) begin
                    post(RK_RELAY, relay_base);
                end else if (phase == PH_SIGN && b == CHAR_PLUS) begin
                    post(RK_RELAY, relay_base + 1);
                end else begin
                    if (phase == PH_DIGIT) begin
                        relay_base = (int'(b) - DIGIT_ZERO) * 10;
                        phase      = PH_SIGN;
                    end
                    if (history == SFX_REL)
                        phase = PH_DIGIT;
                end
            end
        end
    endfunction

    task automatic check_reply();
        reply_t due;
        if (replies_due.size() == 0) begin
            report("result word with nothing due", int'(m_tuser),
                   int'($signed(m_tdata[12:0])));
        end else begin
            due = replies_due.pop_front();
            if (m_tuser !== due.kind)
                report("result kind", int'(m_tuser), int'(due.kind));
            if (m_tdata[12:0] !== due.value)
                report("result value", int'($signed(m_tdata[12:0])),
                       int'($signed(due.value)));
            if (m_tdata[15:13] !== 3'b000)
                report("tdata pad bits", int'(m_tdata[15:13]), 0);
        end
    endtask

    // Result side first: a word accepted now can never be caused by the
    // input word accepted at the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            limit_ms   = TIMEOUT_RESET;
            in_session = 1'b0;
            phase      = PH_PLAIN;
            relay_base = 0;
            elapsed    = '0;
            history    = '0;
            replies_due.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_reply();
            if (cfg_wr_en)
                limit_ms = cfg_wr_data;
            if (s_tvalid && s_tready)
                scan_word(s_tuser, s_tdata);
        end
        pending_count <= replies_due.size();
        fail_count    <= mismatches;
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the request suffix scanner with scan sessions: a short directed run
// over the edge cases, then random sessions built around the request
// suffixes under several timeout settings. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
    import rss_pkg::*;

    localparam logic [1:0] KIND_SPARE  = 2'd3;      // unused kind, ignored
    localparam int         CYCLE_LIMIT = 200_000;
    localparam int         WORD_TARGET = 1100;
    localparam int         NUM_PHASES  = 6;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    wire         s_tready;
    logic [7:0]  s_tdata;     // [7:0] data_byte
    logic [1:0]  s_tuser;     // [1:0] kind
    wire         m_tvalid;
    logic        m_tready;
    wire  [15:0] m_tdata;     // [12:0] result_value, [15:13] zero
    wire  [2:0]  m_tuser;     // [2:0] result_kind

    int          fail_count;
    int          pending_count;
    int          cycles = 0;
    int          words_sent = 0;
    bit          steady = 1'b0;   // no idling on either side
    logic [15:0] timeout_now = TIMEOUT_RESET;

    request_suffix_scanner dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    scan_result_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result sink: random stall before each word
    initial begin
        int stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_word(input logic [1:0] k, input logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // Bytes of a string; when noisy, ticks and spare words slip in between
    task automatic send_text(input string t, input bit noisy);
        for (int i = 0; i < t.len(); i++) begin
            if (noisy && $urandom_range(0, 11) == 0)
                send_word($urandom_range(0, 1) ? KIND_TICK : KIND_SPARE, 8'($urandom));
            send_word(KIND_BYTE, t[i]);
        end
    endtask

    // Wait until every result is out, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        timeout_now = v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] pick_digit();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hff;
            2, 3:    return 8'($urandom);
            default: return 8'(8'h30 + $urandom_range(0, 9));
        endcase
    endfunction

    function automatic string suffix_text(input int i);
        case (i)
            0:       return "+IPD,";
            1:       return "/favicon";
            2:       return "GET / ";
            default: return "GET /?rel";
        endcase
    endfunction

    // One random session: start, some junk, then a request shape
    task automatic run_session();
        int    n;
        string pat;
        string alpha;
        alpha  = "GET /?rel+IPD,favicon-";
        steady = ($urandom_range(0, 3) == 0);
        send_word(KIND_START, 8'($urandom));
        n = $urandom_range(0, 3);
        repeat (n) send_word(KIND_BYTE, 8'($urandom));
        case ($urandom_range(0, 9))
            0: begin
                send_text("+IPD,", 1'b1);
                send_word(KIND_BYTE, pick_digit());
            end
            1: send_text("/favicon", 1'b1);
            2: send_text("GET / ", 1'b1);
            3, 4, 5: begin
                send_text("GET /?rel", 1'b1);
                send_word(KIND_BYTE, pick_digit());
                // a stray byte while the sign is awaited
                if ($urandom_range(0, 3) == 0)
                    send_word(KIND_BYTE, 8'($urandom));
                send_word(KIND_BYTE, $urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
            end
            6: begin
                n = (timeout_now < 30) ? timeout_now + $urandom_range(1, 3)
                                       : $urandom_range(1, 30);
                repeat (n) send_word(KIND_TICK, 8'($urandom));
            end
            7: begin
                // broken request: a cut suffix and a random byte
                pat = suffix_text($urandom_range(0, 3));
                n   = $urandom_range(1, pat.len() - 1);
                send_text(pat.substr(0, n - 1), 1'b1);
                send_word(KIND_BYTE, 8'($urandom));
            end
            8: begin
                // left open; the next start restarts it
                pat = suffix_text($urandom_range(0, 3));
                send_text(pat.substr(0, $urandom_range(0, pat.len() - 2)), 1'b0);
            end
            default: begin
                n = $urandom_range(3, 14);
                repeat (n) send_word(KIND_BYTE, alpha[$urandom_range(0, alpha.len() - 1)]);
            end
        endcase
        // trailing word, often after the session closed
        if ($urandom_range(0, 3) == 0)
            send_word($urandom_range(0, 1) ? KIND_BYTE : KIND_TICK, 8'($urandom));
    endtask

    // Stimulus and verdict
    initial begin
        logic [15:0] limits [NUM_PHASES];
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= KIND_START;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle words, short history, id extremes, restart, relay
        send_word(KIND_BYTE, 8'hff);
        send_word(KIND_TICK, 8'h00);
        send_word(KIND_SPARE, 8'h00);
        send_word(KIND_START, 8'hff);
        send_word(KIND_BYTE, 8'h00);
        send_text("+IPD,", 1'b0);
        send_word(KIND_BYTE, 8'h00);
        send_word(KIND_START, 8'h00);
        send_word(KIND_TICK, 8'hff);
        send_word(KIND_SPARE, 8'hff);
        send_word(KIND_START, 8'h00);
        send_text("GET /?rel", 1'b0);
        send_word(KIND_BYTE, 8'hff);
        send_word(KIND_BYTE, 8'h41);
        send_word(KIND_BYTE, CHAR_PLUS);
        settle();
        write_timeout(16'd0);
        send_word(KIND_START, 8'h00);
        send_word(KIND_TICK, 8'h00);

        // Random sessions under several timeout settings
        limits[0] = 16'd0;
        limits[1] = 16'd2;
        limits[2] = 16'($urandom_range(4, 20));
        limits[3] = 16'hffff;
        limits[4] = TIMEOUT_RESET;
        limits[5] = 16'($urandom_range(0, 65535));
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_timeout(limits[p]);
            while (words_sent < WORD_TARGET * (p + 1) / NUM_PHASES)
                run_session();
        end

        settle();
        if (fail_count == 0 && pending_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
